// ===== rtl/ggf_pkg.sv =====
// Shared types, widths and constants for the gravity Green's function cell.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package ggf_pkg;

    // grid and field widths
    localparam int MAX_EDGE  = 1024;
    localparam int IDX_W     = 10;
    localparam int POS_W     = 32;
    localparam int CW_W      = 31;
    localparam int G_W       = 31;
    localparam int PROD_W    = IDX_W + CW_W;
    localparam int PSUM_W    = PROD_W + 1;
    localparam int SQ_W      = 2 * POS_W;
    localparam int ROOT_W    = 32;
    localparam int RPROD_W   = ROOT_W + CW_W;
    localparam int R_W       = RPROD_W - 16;

    // pipeline depths
    localparam int POS_STAGES  = 4;
    localparam int ISQ_STAGES  = ROOT_W;
    localparam int LOG_STAGES  = 16;

    // factor magnitudes and divider
    localparam int FM3_W     = 60;
    localparam int FM2_W     = 61;
    localparam int QUO_W     = FM3_W - 16;
    localparam int DIV_STAGES = QUO_W;
    localparam int FM2S_W    = FM2_W - 24;

    // log path
    localparam int EXP_W     = 6;
    localparam int FRAC_W    = 16;
    localparam int MANT_W    = 32;
    localparam int L2_W      = 21;
    localparam int MAG_W     = QUO_W;

    // latencies of the side paths, counted from the r register
    localparam int RANK1_LAT = 2;
    localparam int LOG_LAT   = 2 + LOG_STAGES + 2;
    localparam int RANK1_DLY = DIV_STAGES - RANK1_LAT;
    localparam int LOG_DLY   = DIV_STAGES - LOG_LAT;

    // constants
    localparam logic [31:0] K_RANK3 = 32'd341782638;
    localparam logic [31:0] K_RANK2 = 32'd683565276;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [MAG_W-1:0] NEG_CAP = MAG_W'(64'd2147483648);
    localparam logic [MAG_W-1:0] POS_CAP = MAG_W'(64'd2147483647);

    // rank codes
    localparam logic [1:0] RANK_1D = 2'd1;
    localparam logic [1:0] RANK_2D = 2'd2;
    localparam logic [1:0] RANK_3D = 2'd3;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_GRID_RANK   = 3'd0,
        REG_LEFT_EDGE_X = 3'd1,
        REG_LEFT_EDGE_Y = 3'd2,
        REG_LEFT_EDGE_Z = 3'd3,
        REG_CELL_WIDTH  = 3'd4,
        REG_GRAV        = 3'd5
    } cfg_reg_t;

    // per-item control travelling with the data
    typedef struct packed {
        logic valid;
        logic clip;
    } tag_t;

    // clamp an index to the grid edge
    function automatic logic [IDX_W-1:0] idx_clamp(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] wide;
        wide = {1'b0, idx};
        if (wide >= (IDX_W+1)'(MAX_EDGE))
            return IDX_W'(MAX_EDGE - 1);
        else
            return idx;
    endfunction

endpackage

// ===== rtl/ggf_position.sv =====
// Cell position per axis, clipping, squares and their sum (four stages).
// Depends on ggf_pkg.
`timescale 1ns / 1ps

module ggf_position (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ggf_pkg::IDX_W-1:0]   index_x,
    input  logic [ggf_pkg::IDX_W-1:0]   index_y,
    input  logic [ggf_pkg::IDX_W-1:0]   index_z,
    input  logic [ggf_pkg::POS_W-1:0]   left_edge_x,
    input  logic [ggf_pkg::POS_W-1:0]   left_edge_y,
    input  logic [ggf_pkg::POS_W-1:0]   left_edge_z,
    input  logic [ggf_pkg::CW_W-1:0]    cell_width,
    output ggf_pkg::tag_t               tag,
    output logic [ggf_pkg::SQ_W-1:0]    sum
);
    import ggf_pkg::*;

    localparam logic signed [PSUM_W-1:0] P_HI = PSUM_W'(64'sd2147483647);
    localparam logic signed [PSUM_W-1:0] P_LO = -PSUM_W'(64'sd2147483648);

    logic [IDX_W-1:0]  idx_w  [3];
    logic [POS_W-1:0]  edge_w [3];

    logic              valid1_reg;
    tag_t              tag2_reg, tag3_reg, tag4_reg;
    logic [PROD_W-1:0] prod_reg [3];
    logic [POS_W-1:0]  abs_reg  [3];
    logic [POS_W-1:0]  abs_next [3];
    logic [2:0]        clip_next;
    logic [SQ_W-1:0]   sq_reg   [3];
    logic [SQ_W-1:0]   sum_reg;

    logic [PSUM_W-1:0] psum     [3];
    logic [POS_W-1:0]  pclip    [3];

    assign idx_w[0]  = index_x;
    assign idx_w[1]  = index_y;
    assign idx_w[2]  = index_z;
    assign edge_w[0] = left_edge_x;
    assign edge_w[1] = left_edge_y;
    assign edge_w[2] = left_edge_z;

    // position add, clip to signed q16.16, magnitude
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            psum[a] = {{(PSUM_W-POS_W){edge_w[a][POS_W-1]}}, edge_w[a]}
                    + {{(PSUM_W-PROD_W){1'b0}}, prod_reg[a]};
            clip_next[a] = 1'b0;
            if ($signed(psum[a]) > P_HI)
            begin
                pclip[a]     = POS_W'(P_HI);
                clip_next[a] = 1'b1;
            end
            else if ($signed(psum[a]) < P_LO)
            begin
                pclip[a]     = POS_W'(P_LO);
                clip_next[a] = 1'b1;
            end
            else
            begin
                pclip[a] = psum[a][POS_W-1:0];
            end
            abs_next[a] = pclip[a][POS_W-1] ? POS_W'(0 - pclip[a]) : pclip[a];
        end
    end

    // control chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            tag2_reg   <= '0;
            tag3_reg   <= '0;
            tag4_reg   <= '0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            tag2_reg   <= '{valid: valid1_reg, clip: |clip_next};
            tag3_reg   <= tag2_reg;
            tag4_reg   <= tag3_reg;
        end
    end

    // datapath stages: index product, position, square, sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                prod_reg[a] <= PROD_W'(idx_clamp(idx_w[a])) * PROD_W'(cell_width);
                abs_reg[a]  <= abs_next[a];
                sq_reg[a]   <= SQ_W'(abs_reg[a]) * SQ_W'(abs_reg[a]);
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    assign tag = tag4_reg;
    assign sum = sum_reg;

endmodule

// ===== rtl/ggf_isqrt.sv =====
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// Depends on ggf_pkg.
`timescale 1ns / 1ps

module ggf_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  ggf_pkg::tag_t                tag_in,
    input  logic [ggf_pkg::SQ_W-1:0]     value,
    output ggf_pkg::tag_t                tag_out,
    output logic [ggf_pkg::ROOT_W-1:0]   root
);
    import ggf_pkg::*;

    tag_t            tag_reg [ISQ_STAGES];
    logic [SQ_W-1:0] rem_reg [ISQ_STAGES];
    logic [SQ_W-1:0] res_reg [ISQ_STAGES];

    for (genvar k = 0; k < ISQ_STAGES; k++)
    begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);

        tag_t            t_in;
        logic [SQ_W-1:0] rem_in, res_in, trial, rem_next, res_next;

        if (k == 0)
        begin : g_first
            assign t_in   = tag_in;
            assign rem_in = value;
            assign res_in = '0;
        end
        else
        begin : g_rest
            assign t_in   = tag_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        // one restoring step
        always_comb
        begin
            trial = res_in + BIT;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tag_reg[k] <= '0;
            else if (en)
                tag_reg[k] <= t_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                res_reg[k] <= res_next;
            end
        end
    end

    assign tag_out = tag_reg[ISQ_STAGES-1];
    assign root    = res_reg[ISQ_STAGES-1][ROOT_W-1:0];

endmodule

// ===== rtl/ggf_log2.sv =====
// Pipelined log2 of r: leading-one search, normalize, then one squaring
// per fraction bit. Depends on ggf_pkg.
`timescale 1ns / 1ps

module ggf_log2 (
    input  logic                        clk,
    input  logic                        en,
    input  logic [ggf_pkg::R_W-1:0]     r,
    output logic [ggf_pkg::EXP_W-1:0]   exponent,
    output logic [ggf_pkg::FRAC_W-1:0]  frac
);
    import ggf_pkg::*;

    logic [EXP_W-1:0]  lead;
    logic [EXP_W-1:0]  lead_reg;
    logic [R_W-1:0]    r_a_reg;
    logic [R_W-1:0]    norm;
    logic [EXP_W-1:0]  exp_b_reg;
    logic [MANT_W-1:0] mant_b_reg;

    logic [EXP_W-1:0]  exp_reg  [LOG_STAGES];
    logic [MANT_W-1:0] mant_reg [LOG_STAGES];
    logic [FRAC_W-1:0] frac_reg [LOG_STAGES];

    // leading-one position
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < R_W; i++)
        begin
            if (r[i])
                lead = EXP_W'(i);
        end
    end

    // left-justify and keep the top mantissa bits
    assign norm = r_a_reg << (EXP_W'(R_W - 1) - lead_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lead_reg   <= lead;
            r_a_reg    <= r;
            exp_b_reg  <= lead_reg;
            mant_b_reg <= norm[R_W-1 -: MANT_W];
        end
    end

    for (genvar k = 0; k < LOG_STAGES; k++)
    begin : g_sq
        logic [EXP_W-1:0]  e_in;
        logic [MANT_W-1:0] m_in, m_next;
        logic [FRAC_W-1:0] f_in;
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]   top;
        logic              fbit;

        if (k == 0)
        begin : g_first
            assign e_in = exp_b_reg;
            assign m_in = mant_b_reg;
            assign f_in = '0;
        end
        else
        begin : g_rest
            assign e_in = exp_reg[k-1];
            assign m_in = mant_reg[k-1];
            assign f_in = frac_reg[k-1];
        end

        // square the mantissa, renormalize on overflow past two
        always_comb
        begin
            sq   = (2*MANT_W)'(m_in) * (2*MANT_W)'(m_in);
            top  = sq[2*MANT_W-1 -: MANT_W+1];
            fbit = top[MANT_W];
            m_next = fbit ? top[MANT_W:1] : top[MANT_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                exp_reg[k]  <= e_in;
                mant_reg[k] <= m_next;
                frac_reg[k] <= {f_in[FRAC_W-2:0], fbit};
            end
        end
    end

    assign exponent = exp_reg[LOG_STAGES-1];
    assign frac     = frac_reg[LOG_STAGES-1];

endmodule

// ===== rtl/ggf_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage; the user must keep the dividend
// a configuration constant while items are in flight, as the block does not enforce it. Depends on ggf_pkg.
`timescale 1ns / 1ps

module ggf_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  ggf_pkg::tag_t               tag_in,
    input  logic [ggf_pkg::R_W-1:0]     divisor,
    input  logic [ggf_pkg::QUO_W-1:0]   dividend,
    output ggf_pkg::tag_t               tag_out,
    output logic [ggf_pkg::QUO_W-1:0]   quotient
);
    import ggf_pkg::*;

    tag_t             tag_reg [DIV_STAGES];
    logic [R_W-1:0]   rem_reg [DIV_STAGES];
    logic [R_W-1:0]   div_reg [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        tag_t             t_in;
        logic [R_W-1:0]   rem_in, d_in, rem_next;
        logic [QUO_W-1:0] q_in;
        logic [R_W:0]     shifted;
        logic             qbit;

        if (k == 0)
        begin : g_first
            assign t_in   = tag_in;
            assign rem_in = '0;
            assign d_in   = divisor;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign t_in   = tag_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign d_in   = div_reg[k-1];
            assign q_in   = quo_reg[k-1];
        end

        // bring down one dividend bit and try a subtract
        always_comb
        begin
            shifted = {rem_in, dividend[QUO_W-1-k]};
            if (shifted >= {1'b0, d_in})
            begin
                rem_next = R_W'(shifted - {1'b0, d_in});
                qbit     = 1'b1;
            end
            else
            begin
                rem_next = shifted[R_W-1:0];
                qbit     = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tag_reg[k] <= '0;
            else if (en)
                tag_reg[k] <= t_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                div_reg[k] <= d_in;
                quo_reg[k] <= {q_in[QUO_W-2:0], qbit};
            end
        end
    end

    assign tag_out  = tag_reg[DIV_STAGES-1];
    assign quotient = quo_reg[DIV_STAGES-1];

endmodule

// ===== rtl/gravity_greens_function_cell.sv =====
// Top level of the gravity Green's function cell: configuration registers,
// radius stages, rank kernels and output register. Depends on ggf_pkg,
// ggf_position, ggf_isqrt, ggf_log2 and ggf_divider.
`timescale 1ns / 1ps

// Takes one cell per cycle on the slave stream while the pipeline is not held, and
// returns one Green's function value per cell, in order, on the master stream
// through the position and square stages, the square root, the r registers, the
// rank 3 divider (rank 2 and rank 1 run beside it and are delayed to match) and
// the output register. The whole pipeline advances together and holds while the
// output register keeps a result that has not been taken. The user must write
// configuration through the cfg port only while no cell is in flight; the block
// does not enforce it, and writes to indexes past the last register are dropped.

module gravity_greens_function_cell (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream, tdata: index_x [9:0], index_y [19:10], index_z [29:20]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // master stream, tdata: potential [31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // master stream, tuser: saturated [0]
    output logic        m_tuser,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import ggf_pkg::*;

    // configuration registers
    logic [1:0]       grid_rank_reg;
    logic [POS_W-1:0] left_edge_x_reg, left_edge_y_reg, left_edge_z_reg;
    logic [CW_W-1:0]  cell_width_reg;
    logic [G_W-1:0]   grav_reg;
    logic [FM3_W-1:0] fm3_reg;
    logic [FM2_W-1:0] fm2_reg;

    logic en;

    tag_t              pos_tag;
    logic [SQ_W-1:0]   pos_sum;
    tag_t              sq_tag;
    logic [ROOT_W-1:0] sq_root;

    // radius stages
    logic [ROOT_W-1:0]  rad;
    tag_t               rtag1_reg, rtag2_reg;
    logic [RPROD_W-1:0] rprod_reg;
    logic [R_W-1:0]     r_shift;
    logic [R_W-1:0]     r_reg;

    // rank 1 path
    logic [G_W+24-1:0]     r1_lo_reg;
    logic [G_W+R_W-24-1:0] r1_hi_reg;
    logic [G_W+R_W-1:0]    r1_full;
    logic [G_W+R_W-18:0]   r1_shift;
    logic [MAG_W-1:0]      mag1_reg;
    logic [MAG_W-1:0]      mag1_dly_reg [RANK1_DLY];

    // rank 2 path
    logic [EXP_W-1:0]   log_exp;
    logic [FRAC_W-1:0]  log_frac;
    logic               log_pos;
    logic [4:0]         log_int;
    logic [L2_W-1:0]    l2mag;
    logic [L2_W+31:0]   ln_prod;
    logic [L2_W-1:0]    lnmag_reg;
    logic               pos19_reg;
    logic [FM2S_W+L2_W-1:0] mag2_prod;
    logic [MAG_W-1:0]   mag2_reg;
    logic               pos20_reg;
    logic [MAG_W-1:0]   mag2_dly_reg [LOG_DLY];
    logic               pos_dly_reg  [LOG_DLY];

    // rank 3 path
    tag_t               div_tag;
    logic [QUO_W-1:0]   div_quo;

    // final select
    logic [MAG_W-1:0]   mag_sel;
    logic               positive;
    logic               sat;
    logic [31:0]        pot_next;

    logic               out_valid_reg;
    logic [31:0]        out_pot_reg;
    logic               out_sat_reg;

    // the pipeline moves unless a result waits in the output register and is not taken
    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rank_reg   <= RANK_3D;
            left_edge_x_reg <= '0;
            left_edge_y_reg <= '0;
            left_edge_z_reg <= '0;
            cell_width_reg  <= CW_W'(65536);
            grav_reg        <= G_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GRID_RANK:   grid_rank_reg   <= cfg_data[1:0];
                REG_LEFT_EDGE_X: left_edge_x_reg <= cfg_data;
                REG_LEFT_EDGE_Y: left_edge_y_reg <= cfg_data;
                REG_LEFT_EDGE_Z: left_edge_z_reg <= cfg_data;
                REG_CELL_WIDTH:  cell_width_reg  <= cfg_data[CW_W-1:0];
                REG_GRAV:        grav_reg        <= cfg_data[G_W-1:0];
                default:         ;
            endcase
        end
    end

    // factor magnitudes follow the strength register
    always_ff @(posedge clk)
    begin
        fm3_reg <= FM3_W'(grav_reg) * FM3_W'(K_RANK3);
        fm2_reg <= FM2_W'(grav_reg) * FM2_W'(K_RANK2);
    end

    ggf_position u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_tvalid),
        .index_x     (s_tdata[9:0]),
        .index_y     (s_tdata[19:10]),
        .index_z     (s_tdata[29:20]),
        .left_edge_x (left_edge_x_reg),
        .left_edge_y (left_edge_y_reg),
        .left_edge_z (left_edge_z_reg),
        .cell_width  (cell_width_reg),
        .tag         (pos_tag),
        .sum         (pos_sum)
    );

    ggf_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tag_in  (pos_tag),
        .value   (pos_sum),
        .tag_out (sq_tag),
        .root    (sq_root)
    );

    // radius clamp, scale by cell width, raise zero to one ulp
    assign rad     = (sq_root < ROOT_W'(cell_width_reg)) ? ROOT_W'(cell_width_reg) : sq_root;
    assign r_shift = rprod_reg[RPROD_W-1:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rtag1_reg <= '0;
            rtag2_reg <= '0;
        end
        else if (en)
        begin
            rtag1_reg <= sq_tag;
            rtag2_reg <= rtag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rprod_reg <= RPROD_W'(rad) * RPROD_W'(cell_width_reg);
            r_reg     <= (r_shift == '0) ? R_W'(1) : r_shift;
        end
    end

    // rank 3: factor over r
    ggf_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .tag_in   (rtag2_reg),
        .divisor  (r_reg),
        .dividend (fm3_reg[FM3_W-1:16]),
        .tag_out  (div_tag),
        .quotient (div_quo)
    );

    // rank 1: factor times r, in two partial products
    assign r1_full  = (G_W+R_W)'(r1_lo_reg) + ((G_W+R_W)'(r1_hi_reg) << 24);
    assign r1_shift = r1_full[G_W+R_W-1:17];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_lo_reg <= (G_W+24)'(grav_reg) * (G_W+24)'(r_reg[23:0]);
            r1_hi_reg <= (G_W+R_W-24)'(grav_reg) * (G_W+R_W-24)'(r_reg[R_W-1:24]);
            if (r1_shift > (G_W+R_W-17)'(NEG_CAP))
                mag1_reg <= NEG_CAP + MAG_W'(1);
            else
                mag1_reg <= MAG_W'(r1_shift);
        end
    end

    // rank 2: factor times ln r
    ggf_log2 u_log2 (
        .clk      (clk),
        .en       (en),
        .r        (r_reg),
        .exponent (log_exp),
        .frac     (log_frac)
    );

    assign log_pos   = log_exp < EXP_W'(16);
    assign log_int   = log_pos ? 5'(EXP_W'(16) - log_exp) : 5'(log_exp - EXP_W'(16));
    assign l2mag     = log_pos ? ({log_int, FRAC_W'(0)} - L2_W'(log_frac))
                               : ({log_int, FRAC_W'(0)} + L2_W'(log_frac));
    assign ln_prod   = (L2_W+32)'(l2mag) * (L2_W+32)'(LN2_Q32);
    assign mag2_prod = (FM2S_W+L2_W)'(fm2_reg[FM2_W-1:24]) * (FM2S_W+L2_W)'(lnmag_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lnmag_reg <= ln_prod[L2_W+31:32];
            pos19_reg <= log_pos;
            mag2_reg  <= MAG_W'(mag2_prod[FM2S_W+L2_W-1:24]);
            pos20_reg <= pos19_reg;
        end
    end

    // align the side paths with the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_dly_reg[0] <= mag1_reg;
            for (int i = 1; i < RANK1_DLY; i++)
                mag1_dly_reg[i] <= mag1_dly_reg[i-1];
            mag2_dly_reg[0] <= mag2_reg;
            pos_dly_reg[0]  <= pos20_reg;
            for (int i = 1; i < LOG_DLY; i++)
            begin
                mag2_dly_reg[i] <= mag2_dly_reg[i-1];
                pos_dly_reg[i]  <= pos_dly_reg[i-1];
            end
        end
    end

    // kernel select, sign and saturation
    always_comb
    begin
        positive = 1'b0;
        case (grid_rank_reg)
            RANK_3D: mag_sel = div_quo;
            RANK_2D:
            begin
                mag_sel  = mag2_dly_reg[LOG_DLY-1];
                positive = pos_dly_reg[LOG_DLY-1];
            end
            RANK_1D: mag_sel = mag1_dly_reg[RANK1_DLY-1];
            default: mag_sel = '0;
        endcase

        if (positive)
        begin
            sat      = mag_sel > POS_CAP;
            pot_next = sat ? POS_CAP[31:0] : mag_sel[31:0];
        end
        else
        begin
            sat      = mag_sel > NEG_CAP;
            pot_next = sat ? NEG_CAP[31:0] : 32'(0 - mag_sel[31:0]);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= div_tag.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_pot_reg <= pot_next;
            out_sat_reg <= div_tag.clip | sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pot_reg;
    assign m_tuser  = out_sat_reg;

endmodule
